// ----- hw/rtl/kmds_pkg.sv -----
`default_nettype none

package kmds_pkg;

    localparam int KEY_ROWS   = 4;
    localparam int KEY_COLS   = 4;
    localparam int TIME_WIDTH = 32;

    localparam int KEY_MAP_W  = 16;
    localparam int KEY_TOTAL  = (KEY_ROWS * KEY_COLS < KEY_MAP_W) ? KEY_ROWS * KEY_COLS
                                                                  : KEY_MAP_W;
    localparam int NOW_W      = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int INDEX_W    = 4;
    localparam int CHAR_W     = 7;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

    localparam int LEGEND_ROWS = 4;
    localparam int LEGEND_COLS = 4;

    localparam logic [CHAR_W-1:0] LEGEND_MAP [LEGEND_ROWS][LEGEND_COLS] = '{
        '{7'h31, 7'h32, 7'h33, 7'h41},
        '{7'h34, 7'h35, 7'h36, 7'h42},
        '{7'h37, 7'h38, 7'h39, 7'h43},
        '{7'h2A, 7'h30, 7'h23, 7'h44}
    };

    typedef logic [TIME_WIDTH-1:0] stamp_t;

    typedef struct packed {
        logic               last_valid;
        logic [INDEX_W-1:0] last_index;
        logic               wait_release;
        logic [INDEX_W-1:0] wait_index;
    } track_t;

    typedef struct packed {
        logic               key_valid;
        logic [INDEX_W-1:0] key_index;
        logic [CHAR_W-1:0]  key_char;
    } key_result_t;

    function automatic logic [CHAR_W-1:0] legend_of(input logic [INDEX_W-1:0] pos);
        int row;
        int col;
        row = int'(pos) / KEY_COLS;
        col = int'(pos) % KEY_COLS;
        if (row < LEGEND_ROWS && col < LEGEND_COLS)
        begin
            return LEGEND_MAP[2'(row)][2'(col)];
        end
        return '0;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kmds_intf.sv -----
`default_nettype none

interface kmds_scan_if;
    import kmds_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KEY_MAP_W-1:0] key_closed;
    logic [NOW_W-1:0]     now_ms;

    modport source (output valid, output key_closed, output now_ms, input ready);
    modport sink   (input valid, input key_closed, input now_ms, output ready);
endinterface

interface kmds_key_if;
    import kmds_pkg::*;

    logic               valid;
    logic               ready;
    logic               key_valid;
    logic [INDEX_W-1:0] key_index;
    logic [CHAR_W-1:0]  key_char;

    modport source (output valid, output key_valid, output key_index, output key_char,
                    input ready);
    modport sink   (input valid, input key_valid, input key_index, input key_char,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/kmds_scan.sv -----
`default_nettype none

module kmds_scan (
    input  wire logic [kmds_pkg::KEY_MAP_W-1:0]  key_closed,
    input  wire kmds_pkg::stamp_t                now,
    input  wire logic [kmds_pkg::DEBOUNCE_W-1:0] debounce,
    input  wire logic [kmds_pkg::KEY_TOTAL-1:0]  pressed_q,
    input  wire kmds_pkg::stamp_t                stamps_q [kmds_pkg::KEY_TOTAL],
    input  wire kmds_pkg::track_t                track_q,
    output      logic [kmds_pkg::KEY_TOTAL-1:0]  pressed_d,
    output      logic [kmds_pkg::KEY_TOTAL-1:0]  stamp_we,
    output      kmds_pkg::track_t                track_d,
    output      kmds_pkg::key_result_t           result
);
    import kmds_pkg::*;

    logic                 hold;
    logic [KEY_TOTAL-1:0] cand;
    logic [KEY_TOTAL-1:0] active;
    logic                 found;
    logic [INDEX_W-1:0]   pick;

    assign hold = track_q.wait_release && key_closed[track_q.wait_index];

    // per-key debounce check, all keys in parallel
    always_comb
    begin
        for (int i = 0; i < KEY_TOTAL; i++)
        begin
            cand[i] = key_closed[i] && pressed_q[i]
                   && ((now - stamps_q[i]) >= TIME_WIDTH'(debounce))
                   && !(track_q.last_valid && track_q.last_index == INDEX_W'(i));
        end
    end

    // first candidate in row-major order; keys past it keep their state
    always_comb
    begin
        found  = 1'b0;
        pick   = '0;
        active = '0;
        for (int i = 0; i < KEY_TOTAL; i++)
        begin
            active[i] = !found;
            if (cand[i] && !found)
            begin
                found = 1'b1;
                pick  = INDEX_W'(i);
            end
        end
    end

    always_comb
    begin
        pressed_d = pressed_q;
        stamp_we  = '0;
        track_d   = track_q;
        result    = '0;
        if (!hold)
        begin
            for (int i = 0; i < KEY_TOTAL; i++)
            begin
                if (active[i])
                begin
                    if (!key_closed[i])
                    begin
                        pressed_d[i] = 1'b0;
                    end
                    else if (!pressed_q[i])
                    begin
                        pressed_d[i] = 1'b1;
                        stamp_we[i]  = 1'b1;
                    end
                end
            end
            if (found)
            begin
                track_d.last_valid   = 1'b1;
                track_d.last_index   = pick;
                track_d.wait_release = 1'b1;
                track_d.wait_index   = pick;
                result.key_valid     = 1'b1;
                result.key_index     = pick;
                result.key_char      = legend_of(pick);
            end
            else
            begin
                track_d.last_valid   = 1'b0;
                track_d.last_index   = '0;
                track_d.wait_release = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/keypad_matrix_debounce_scanner_top.sv -----
// A scan passes the input register, then the result register. Throughput: one
// scan per cycle while the key channel does not stall; the per-key debounce
// compare and priority pick over all keys sit in one stage between the input
// and result registers. Reset (rst_n low, asynchronous): pressed marks, release
// tracking and both pipeline valid flags clear, debounce_ms returns to 20; press
// stamps are not reset and are only read once their key has been marked pressed.
`default_nettype none

module keypad_matrix_debounce_scanner_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [kmds_pkg::DEBOUNCE_W-1:0] cfg_wdata,
    kmds_scan_if.sink                            scan,
    kmds_key_if.source                           key
);
    import kmds_pkg::*;

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [KEY_TOTAL-1:0]  pressed_reg;
    logic [KEY_TOTAL-1:0]  pressed_next;
    stamp_t                stamps_reg [KEY_TOTAL];
    track_t                track_reg;
    track_t                track_next;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [KEY_MAP_W-1:0]  in_closed_reg;
    stamp_t                in_now_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    key_result_t           out_result_reg;
    key_result_t           out_result_next;

    logic                  process;
    logic                  in_take;
    logic [KEY_TOTAL-1:0]  stamp_we;

    assign process   = in_valid_reg && (!out_valid_reg || key.ready);
    assign scan.ready = !in_valid_reg || process;
    assign in_take   = scan.valid && scan.ready;

    assign key.valid     = out_valid_reg;
    assign key.key_valid = out_result_reg.key_valid;
    assign key.key_index = out_result_reg.key_index;
    assign key.key_char  = out_result_reg.key_char;

    kmds_scan u_scan (
        .key_closed (in_closed_reg),
        .now        (in_now_reg),
        .debounce   (debounce_reg),
        .pressed_q  (pressed_reg),
        .stamps_q   (stamps_reg),
        .track_q    (track_reg),
        .pressed_d  (pressed_next),
        .stamp_we   (stamp_we),
        .track_d    (track_next),
        .result     (out_result_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (process)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (process)
        begin
            out_valid_next = 1'b1;
        end
        else if (key.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            pressed_reg   <= '0;
            track_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                debounce_reg <= cfg_wdata;
            end
            if (process)
            begin
                pressed_reg <= pressed_next;
                track_reg   <= track_next;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_closed_reg <= scan.key_closed;
            in_now_reg    <= scan.now_ms[TIME_WIDTH-1:0];
        end
        if (process)
        begin
            out_result_reg <= out_result_next;
            for (int i = 0; i < KEY_TOTAL; i++)
            begin
                if (stamp_we[i])
                begin
                    stamps_reg[i] <= in_now_reg;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/keypad_matrix_debounce_scanner_top_tb.sv -----
`timescale 1ns / 1ps

module keypad_matrix_debounce_scanner_top_tb;
    import kmds_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;

    localparam logic [7:0] KEY_LEGENDS [16] = '{
        "1", "2", "3", "A",
        "4", "5", "6", "B",
        "7", "8", "9", "C",
        "*", "0", "#", "D"
    };

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_QUARTER,
        RDY_SPARSE
    } ready_mode_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [DEBOUNCE_W-1:0] cfg_wdata;

    kmds_scan_if scan_bus ();
    kmds_key_if  key_bus ();

    keypad_matrix_debounce_scanner_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .scan      (scan_bus),
        .key       (key_bus)
    );

    // scanner state mirror
    logic [KEY_MAP_W-1:0]  pressed_mask;
    logic [NOW_W-1:0]      stamp_mirror [KEY_MAP_W];
    logic                  last_key_valid;
    logic [INDEX_W-1:0]    last_key_idx;
    logic                  release_wait;
    logic [INDEX_W-1:0]    release_idx;
    logic [DEBOUNCE_W-1:0] debounce_limit;

    key_result_t pending_keys [$];
    key_result_t exp_key;

    int fail_count;
    int scans_sent;
    int keys_reported;
    int settings_used;
    int burst_left;
    int idle_cycles;
    int sink_cycle;
    ready_mode_t sink_mode;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic key_result_t predict_key_report(input logic [KEY_MAP_W-1:0] closed,
                                                       input logic [NOW_W-1:0] now);
        key_result_t res;
        logic [NOW_W-1:0] elapsed;
        logic hit;
        res = '0;
        hit = 1'b0;
        if (release_wait)
        begin
            if (closed[release_idx])
            begin
                return res;
            end
            release_wait = 1'b0;
        end
        for (int k = 0; k < KEY_TOTAL; k++)
        begin
            if (!hit)
            begin
                if (closed[k])
                begin
                    if (!pressed_mask[k])
                    begin
                        pressed_mask[k] = 1'b1;
                        stamp_mirror[k] = now;
                    end
                    else
                    begin
                        elapsed = now - stamp_mirror[k];
                        if (elapsed >= NOW_W'(debounce_limit)
                            && !(last_key_valid && last_key_idx == INDEX_W'(k)))
                        begin
                            hit = 1'b1;
                            last_key_valid = 1'b1;
                            last_key_idx = INDEX_W'(k);
                            release_wait = 1'b1;
                            release_idx = INDEX_W'(k);
                            res.key_valid = 1'b1;
                            res.key_index = INDEX_W'(k);
                            res.key_char = KEY_LEGENDS[k][CHAR_W-1:0];
                        end
                    end
                end
                else
                begin
                    pressed_mask[k] = 1'b0;
                end
            end
        end
        if (!hit)
        begin
            last_key_valid = 1'b0;
            last_key_idx = '0;
        end
        return res;
    endfunction

    task automatic send_scan(input logic [KEY_MAP_W-1:0] closed, input logic [NOW_W-1:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                scan_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        scan_bus.valid      <= 1'b1;
        scan_bus.key_closed <= closed;
        scan_bus.now_ms     <= now;
        @(posedge clk);
        while (!scan_bus.ready)
        begin
            @(posedge clk);
        end
        pending_keys.push_back(predict_key_report(closed, now));
        scans_sent++;
        burst_left--;
    endtask

    task automatic drain_results;
        scan_bus.valid <= 1'b0;
        burst_left = 0;
        while (pending_keys.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_debounce(input logic [DEBOUNCE_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        debounce_limit = value;
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic test_debounce_and_release;
        send_scan(16'h0001, 32'd1000);
        send_scan(16'h0001, 32'd1019);
        send_scan(16'h0001, 32'd1020);
        send_scan(16'h0001, 32'd1500);
        send_scan(16'h0000, 32'd1501);
    endtask

    task automatic test_first_press_zero_debounce;
        set_debounce(16'd0);
        send_scan(16'h8000, 32'd5);
        send_scan(16'h8000, 32'd5);
        send_scan(16'h0000, 32'd6);
    endtask

    task automatic test_priority_all_keys;
        set_debounce(16'd1);
        send_scan(16'hFFFF, 32'd10);
        send_scan(16'hFFFF, 32'd11);
        send_scan(16'hFFFE, 32'd11);
        send_scan(16'h0000, 32'd12);
    endtask

    task automatic test_max_debounce_wrap;
        set_debounce(16'hFFFF);
        send_scan(16'h0400, 32'hFFFF_8000);
        send_scan(16'h0400, 32'h0000_7FFE);
        send_scan(16'h0400, 32'h0000_7FFF);
        send_scan(16'h0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_contact_bounce;
        set_debounce(16'd20);
        send_scan(16'h0020, 32'd0);
        send_scan(16'h0000, 32'd10);
        send_scan(16'h0020, 32'd25);
        send_scan(16'h0020, 32'd40);
        send_scan(16'h0020, 32'd45);
        send_scan(16'h0000, 32'd46);
    endtask

    task automatic run_typing_phase(input logic [DEBOUNCE_W-1:0] hold_ms, input int scans);
        logic [KEY_MAP_W-1:0] held;
        logic [KEY_MAP_W-1:0] closed;
        logic [NOW_W-1:0] now;
        int pick;
        set_debounce(hold_ms);
        held = '0;
        now = $urandom();
        for (int n = 0; n < scans; n++)
        begin
            if (n == scans / 2)
            begin
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (release_wait && $urandom_range(0, 99) < 35)
            begin
                held[release_idx] = 1'b0;
            end
            if (pick < 14)
            begin
                held ^= KEY_MAP_W'(1) << $urandom_range(0, KEY_MAP_W - 1);
            end
            else if (pick < 17)
            begin
                held = '0;
            end
            else if (pick < 19)
            begin
                held = KEY_MAP_W'($urandom());
            end
            closed = held;
            if (pick >= 88 && pick < 93)
            begin
                closed ^= KEY_MAP_W'(1) << $urandom_range(0, KEY_MAP_W - 1);
            end
            if (pick >= 96)
            begin
                closed = KEY_MAP_W'($urandom());
                now = $urandom();
            end
            else
            begin
                now += NOW_W'($urandom_range(0, int'(hold_ms) / 2 + 2));
            end
            send_scan(closed, now);
        end
    endtask

    task automatic test_random_typing;
        run_typing_phase(16'd0, 230);
        run_typing_phase(16'd1, 230);
        run_typing_phase(16'd20, 230);
        run_typing_phase(16'd300, 230);
        run_typing_phase(16'($urandom_range(2, 2000)), 230);
        run_typing_phase(16'd7, 230);
        run_typing_phase(16'hFFFF, 230);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        scan_bus.valid      = 1'b0;
        scan_bus.key_closed = '0;
        scan_bus.now_ms     = '0;
        key_bus.ready       = 1'b0;
        pressed_mask        = '0;
        last_key_valid      = 1'b0;
        last_key_idx        = '0;
        release_wait        = 1'b0;
        release_idx         = '0;
        debounce_limit      = DEBOUNCE_RESET;
        fail_count          = 0;
        scans_sent          = 0;
        keys_reported       = 0;
        settings_used       = 0;
        burst_left          = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_debounce_and_release();
        test_first_press_zero_debounce();
        test_priority_all_keys();
        test_max_debounce_wrap();
        test_contact_bounce();
        test_random_typing();

        drain_results();
        repeat (8) @(posedge clk);
        $display("Ran %0d scans with %0d debounced key reports over %0d debounce settings",
                 scans_sent, keys_reported, settings_used);
        $display("Settings spanned 0 to 65535 ms, with time wrap, bounce and release waits");
        if (fail_count == 0)
        begin
            $display("keypad_matrix_debounce_scanner_top verification clean");
        end
        else
        begin
            $display("keypad_matrix_debounce_scanner_top verification failed");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        sink_cycle <= sink_cycle + 1;
        if (sink_cycle % 97 == 0)
        begin
            sink_mode <= ready_mode_t'($urandom_range(0, 3));
        end
        case (sink_mode)
            RDY_ALWAYS:  key_bus.ready <= 1'b1;
            RDY_RANDOM:  key_bus.ready <= 1'($urandom_range(0, 1));
            RDY_QUARTER: key_bus.ready <= (sink_cycle % 4 == 0);
            default:     key_bus.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    initial
    begin
        sink_cycle = 0;
        sink_mode  = RDY_ALWAYS;
    end

    always @(posedge clk)
    begin
        if (rst_n && key_bus.valid && key_bus.ready)
        begin
            if (pending_keys.size() == 0)
            begin
                $error("key transaction with no scan pending");
                fail_count++;
            end
            else
            begin
                exp_key = pending_keys.pop_front();
                if (key_bus.key_valid)
                begin
                    keys_reported++;
                end
                if (key_bus.key_valid !== exp_key.key_valid)
                begin
                    $error("key_valid: expected %0d, got %0d", exp_key.key_valid,
                           key_bus.key_valid);
                    fail_count++;
                end
                if (key_bus.key_index !== exp_key.key_index)
                begin
                    $error("key_index: expected %0d, got %0d", exp_key.key_index,
                           key_bus.key_index);
                    fail_count++;
                end
                if (key_bus.key_char !== exp_key.key_char)
                begin
                    $error("key_char: expected 0x%02h, got 0x%02h", exp_key.key_char,
                           key_bus.key_char);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (scan_bus.valid && scan_bus.ready) || (key_bus.valid && key_bus.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("keypad_matrix_debounce_scanner_top verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        idle_cycles = 0;
    end

endmodule

// ----- keypad_matrix_debounce_scanner_top.f -----
hw/rtl/kmds_pkg.sv
hw/rtl/kmds_intf.sv
hw/rtl/kmds_scan.sv
hw/rtl/keypad_matrix_debounce_scanner_top.sv
tb/sv/keypad_matrix_debounce_scanner_top_tb.sv
